FILE: hw/rtl/lzwe_pkg.sv
// Shared constants and types for the LZW variable width encoder.
// No dependencies; used by every module in hw/rtl except lzwe_ram.
package lzwe_pkg;

  localparam int MAX_CODE_BITS_DEF = 13;
  localparam int DICT_ENTRIES_DEF  = 8192;

  localparam int CODE_FW  = 16;  // widest code the request carries
  localparam int WIDTH_FW = 5;   // holds a code width of up to 16
  localparam int ACC_W    = 7 + CODE_FW;
  localparam int CNT_W    = 5;

  localparam logic [CODE_FW-1:0]  CODE_CLEAR  = 16'd256;
  localparam logic [CODE_FW-1:0]  CODE_EOF    = 16'd257;
  localparam int                  CODE_FIRST  = 258;
  localparam logic [WIDTH_FW-1:0] START_WIDTH = 5'd9;
  localparam int                  START_LIMIT = 512;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // one code for the bit packer
  typedef struct packed {
    logic [CODE_FW-1:0]  code;
    logic [WIDTH_FW-1:0] width;
    logic                run_last;  // last code caused by its input request
    logic                flush;     // end of member: pad out the last byte
  } code_req_t;

endpackage

FILE: hw/rtl/lzwe_ram.sv
// Generic simple dual port RAM, one write and one registered read a cycle.
// No dependencies.
module lzwe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/lzwe_code_fifo.sv
// Short queue of code requests between the dictionary front end and the packer.
// Depends on lzwe_pkg.
module lzwe_code_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  lzwe_pkg::code_req_t wdata,
  output logic               full,
  input  logic               rd,
  output lzwe_pkg::code_req_t rdata,
  output logic               empty
);

  localparam int DEPTH = 4;

  lzwe_pkg::code_req_t slots [DEPTH];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;

  assign full  = (count == 3'(DEPTH));
  assign empty = (count == 3'd0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= wptr + 2'd1;
      end
      if (rd && !empty) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + 3'(wr && !full) - 3'(rd && !empty);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(wr && full))
    else $error("code push while queue full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(rd && empty))
    else $error("code pop while queue empty");
`endif

endmodule

FILE: hw/rtl/lzwe_front.sv
// Dictionary front end: takes input requests, walks the child/sibling tree,
// updates it, and queues codes. Depends on lzwe_pkg and lzwe_ram.
module lzwe_front #(
  parameter int MAX_CODE_BITS = lzwe_pkg::MAX_CODE_BITS_DEF,
  parameter int DICT_ENTRIES  = lzwe_pkg::DICT_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                operation,
  input  logic [7:0]          data_byte,
  output logic                busy,
  output logic                code_wr,
  output lzwe_pkg::code_req_t code_req,
  input  logic                code_full
);

  localparam int L      = $clog2(DICT_ENTRIES);
  localparam int WORD_W = 2 * L + 8;
  localparam int FREE_W = $clog2(DICT_ENTRIES + 2);
  localparam int LIM_W  = MAX_CODE_BITS + 1;
  localparam int CMP_W  = (FREE_W > LIM_W) ? FREE_W : LIM_W;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ROOT     = 7'b0000010,
    S_WALK     = 7'b0000100,
    S_UPD_LINK = 7'b0001000,
    S_UPD_NEW  = 7'b0010000,
    S_PUSH_A   = 7'b0100000,
    S_PUSH_B   = 7'b1000000
  } state_t;

  state_t              state;
  logic [7:0]          ch;
  logic [L-1:0]        match;
  logic [FREE_W-1:0]   free;
  logic [lzwe_pkg::WIDTH_FW-1:0] cwidth;
  logic [LIM_W-1:0]    limit;
  logic                open;
  logic [255:0]        root_valid;
  logic [L-1:0]        idx;
  logic [L-1:0]        where;
  logic [WORD_W-1:0]   where_word;
  logic                status_root;
  lzwe_pkg::code_req_t req_a;
  lzwe_pkg::code_req_t req_b;
  logic                has_b;

  logic                we;
  logic [L-1:0]        waddr;
  logic [WORD_W-1:0]   wdata;
  logic [L-1:0]        raddr;
  logic [WORD_W-1:0]   rdata;

  logic [L-1:0]        rd_child;
  logic [L-1:0]        rd_sib;
  logic [7:0]          rd_chr;
  logic                match_is_root;
  logic [L-1:0]        root_child;
  logic                free_ok;
  logic [L-1:0]        link;
  logic [FREE_W-1:0]   free_inc;
  logic                grow;
  logic                at_max;

  lzwe_ram #(.WIDTH(WORD_W), .DEPTH(DICT_ENTRIES)) u_dict (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_child      = rdata[WORD_W-1 -: L];
  assign rd_sib        = rdata[L+7:8];
  assign rd_chr        = rdata[7:0];
  assign match_is_root = (match[L-1:8] == '0);
  assign root_child    = (match_is_root && !root_valid[match[7:0]]) ? '0 : rd_child;
  assign free_ok       = (free < FREE_W'(DICT_ENTRIES));
  assign link          = free_ok ? free[L-1:0] : '0;
  assign free_inc      = (free <= FREE_W'(DICT_ENTRIES)) ? free + 1'b1 : free;
  assign grow          = (CMP_W'(free_inc) > CMP_W'(limit));
  assign at_max        = (cwidth >= lzwe_pkg::WIDTH_FW'(MAX_CODE_BITS));

  assign busy     = (state != S_IDLE);
  assign code_wr  = ((state == S_PUSH_A) || (state == S_PUSH_B)) && !code_full;
  assign code_req = (state == S_PUSH_B) ? req_b : req_a;

  always_comb begin
    raddr = match;
    we    = 1'b0;
    waddr = where;
    wdata = where_word;
    case (state)
      S_ROOT: raddr = root_child;
      S_WALK: raddr = rd_sib;
      S_UPD_LINK: begin
        we = 1'b1;
        if (status_root) begin
          wdata = {link, where_word[L+7:0]};
        end else begin
          wdata = {where_word[WORD_W-1 -: L], link, where_word[7:0]};
        end
      end
      S_UPD_NEW: begin
        we    = free_ok;
        waddr = free[L-1:0];
        wdata = {{(2 * L){1'b0}}, ch};
      end
      default: raddr = match;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      match      <= '0;
      free       <= FREE_W'(lzwe_pkg::CODE_FIRST);
      cwidth     <= lzwe_pkg::START_WIDTH;
      limit      <= LIM_W'(lzwe_pkg::START_LIMIT);
      open       <= 1'b0;
      root_valid <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (push) begin
            ch <= data_byte;
            if (operation == lzwe_pkg::OP_DATA) begin
              if (!open) begin
                free       <= FREE_W'(lzwe_pkg::CODE_FIRST);
                cwidth     <= lzwe_pkg::START_WIDTH;
                limit      <= LIM_W'(lzwe_pkg::START_LIMIT);
                root_valid <= '0;
                match      <= L'(data_byte);
                open       <= 1'b1;
                req_a      <= '{lzwe_pkg::CODE_CLEAR, lzwe_pkg::START_WIDTH, 1'b1, 1'b0};
                has_b      <= 1'b0;
                state      <= S_PUSH_A;
              end else begin
                state <= S_ROOT;
              end
            end else begin
              if (!open) begin
                free       <= FREE_W'(lzwe_pkg::CODE_FIRST);
                cwidth     <= lzwe_pkg::START_WIDTH;
                limit      <= LIM_W'(lzwe_pkg::START_LIMIT);
                root_valid <= '0;
                req_a <= '{lzwe_pkg::CODE_CLEAR, lzwe_pkg::START_WIDTH, 1'b0, 1'b0};
                req_b <= '{lzwe_pkg::CODE_EOF, lzwe_pkg::START_WIDTH, 1'b1, 1'b1};
              end else begin
                req_a <= '{lzwe_pkg::CODE_FW'(match), cwidth, 1'b0, 1'b0};
                req_b <= '{lzwe_pkg::CODE_EOF, cwidth, 1'b1, 1'b1};
              end
              has_b <= 1'b1;
              match <= '0;
              open  <= 1'b0;
              state <= S_PUSH_A;
            end
          end
        end
        S_ROOT: begin
          where       <= match;
          where_word  <= rdata;
          status_root <= 1'b1;
          idx         <= root_child;
          state       <= (root_child == '0) ? S_UPD_LINK : S_WALK;
        end
        S_WALK: begin
          if (rd_chr == ch) begin
            match <= idx;
            state <= S_IDLE;
          end else begin
            where       <= idx;
            where_word  <= rdata;
            status_root <= 1'b0;
            idx         <= rd_sib;
            if (rd_sib == '0) begin
              state <= S_UPD_LINK;
            end
          end
        end
        S_UPD_LINK: begin
          if (status_root && (where[L-1:8] == '0)) begin
            root_valid[where[7:0]] <= 1'b1;
          end
          state <= S_UPD_NEW;
        end
        S_UPD_NEW: begin
          req_a <= '{lzwe_pkg::CODE_FW'(match), cwidth, !(grow && at_max), 1'b0};
          req_b <= '{lzwe_pkg::CODE_CLEAR, cwidth, 1'b1, 1'b0};
          has_b <= grow && at_max;
          match <= L'(ch);
          if (grow && at_max) begin
            // dictionary restarts after the CLEAR at the old width
            free       <= FREE_W'(lzwe_pkg::CODE_FIRST);
            cwidth     <= lzwe_pkg::START_WIDTH;
            limit      <= LIM_W'(lzwe_pkg::START_LIMIT);
            root_valid <= '0;
          end else begin
            free <= free_inc;
            if (grow) begin
              cwidth <= cwidth + 1'b1;
              limit  <= {limit[LIM_W-2:0], 1'b0};
            end
          end
          state <= S_PUSH_A;
        end
        S_PUSH_A: begin
          if (!code_full) begin
            state <= has_b ? S_PUSH_B : S_IDLE;
          end
        end
        S_PUSH_B: begin
          if (!code_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_walk_link: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (idx != '0))
    else $error("tree walk on a null link");
`endif

endmodule

FILE: hw/rtl/lzwe_packer.sv
// Bit packer: turns queued codes into bytes LSB first, one byte a cycle while
// the result register is free, and holds that register. Depends on lzwe_pkg.
module lzwe_packer (
  input  logic                clk,
  input  logic                rst,
  input  logic                code_empty,
  input  lzwe_pkg::code_req_t code_req,
  output logic                code_rd,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          packed_byte,
  output logic                run_last,
  output logic                member_last
);

  logic [lzwe_pkg::ACC_W-1:0] acc;
  logic [lzwe_pkg::CNT_W-1:0] cnt;
  logic                       busy;
  logic                       pad;
  logic                       req_last;
  logic                       req_flush;
  logic                       out_valid;

  logic                        slot_free;
  logic                        emit;
  logic [lzwe_pkg::CNT_W-1:0]  rem;
  logic                        fin;
  logic [lzwe_pkg::CODE_FW-1:0] mask;

  assign slot_free = !out_valid || pop;
  assign emit      = (pad || busy) && slot_free;
  assign rem       = cnt - lzwe_pkg::CNT_W'(8);
  assign fin       = (rem < lzwe_pkg::CNT_W'(8));
  assign mask      = ~({lzwe_pkg::CODE_FW{1'b1}} << code_req.width);
  assign code_rd   = !busy && !pad && !code_empty;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      busy      <= 1'b0;
      pad       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !pop);
      if (pad) begin
        if (slot_free) begin
          packed_byte <= acc[7:0];
          run_last    <= 1'b1;
          member_last <= 1'b1;
          pad         <= 1'b0;
          acc         <= '0;
          cnt         <= '0;
        end
      end else if (busy) begin
        if (slot_free) begin
          packed_byte <= acc[7:0];
          acc         <= acc >> 8;
          cnt         <= rem;
          run_last    <= fin && req_last && !(req_flush && (rem != '0));
          member_last <= fin && req_flush && (rem == '0);
          if (fin) begin
            busy <= 1'b0;
            pad  <= req_flush && (rem != '0);
          end
        end
      end else if (!code_empty) begin
        acc       <= acc | (lzwe_pkg::ACC_W'(code_req.code & mask) << cnt);
        cnt       <= cnt + lzwe_pkg::CNT_W'(code_req.width);
        req_last  <= code_req.run_last;
        req_flush <= code_req.flush;
        busy      <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pending_short: assert property (@(posedge clk) disable iff (rst)
    (!busy && !pad) |-> (cnt < lzwe_pkg::CNT_W'(8)))
    else $error("whole byte left pending between codes");
  a_pad_after_flush: assert property (@(posedge clk) disable iff (rst)
    $rose(pad) |-> (req_flush && (cnt != '0)))
    else $error("pad byte without end of member");
`endif

endmodule

FILE: hw/rtl/lzw_variable_width_encoder_unit.sv
// Top level of the LZW variable width encoder (9 bits up to MAX_CODE_BITS).
// Depends on lzwe_pkg, lzwe_front, lzwe_code_fifo, lzwe_packer, lzwe_ram.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   input    | push / full          | operation, data_byte
//   result   | pop / empty          | packed_byte, run_last, member_last
//
// A data byte takes S_ROOT and one registered S_WALK read per sibling visited
// in the dictionary RAM; a miss adds S_UPD_LINK, S_UPD_NEW, 1-2 code pushes;
// an end marker pushes two codes. The packer drains one byte a cycle unstalled.
// Reset is synchronous; root links are cleared by 256 valid bits, no RAM sweep.
// full is high while the front end works on a request; the code queue and the
// result register let the front end run ahead of a stalled pop.
module lzw_variable_width_encoder_unit #(
  parameter int MAX_CODE_BITS = lzwe_pkg::MAX_CODE_BITS_DEF,
  parameter int DICT_ENTRIES  = lzwe_pkg::DICT_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       operation,
  input  logic [7:0] data_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] packed_byte,
  output logic       run_last,
  output logic       member_last
);

  logic                code_wr;
  lzwe_pkg::code_req_t code_in;
  logic                code_full;
  logic                code_rd;
  lzwe_pkg::code_req_t code_out;
  logic                code_empty;

  lzwe_front #(
    .MAX_CODE_BITS(MAX_CODE_BITS),
    .DICT_ENTRIES (DICT_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .operation(operation),
    .data_byte(data_byte),
    .busy     (full),
    .code_wr  (code_wr),
    .code_req (code_in),
    .code_full(code_full)
  );

  lzwe_code_fifo u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (code_wr),
    .wdata(code_in),
    .full (code_full),
    .rd   (code_rd),
    .rdata(code_out),
    .empty(code_empty)
  );

  lzwe_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .code_empty (code_empty),
    .code_req   (code_out),
    .code_rd    (code_rd),
    .empty      (empty),
    .pop        (pop),
    .packed_byte(packed_byte),
    .run_last   (run_last),
    .member_last(member_last)
  );

endmodule

FILE: test/lzw_variable_width_encoder_unit_chk.sv
// Checker for the LZW variable width encoder: predicts packed bytes per request.
// Depends on lzwe_pkg; watches the push and pop channels of the top level.
`timescale 1ns / 1ps

module lzw_variable_width_encoder_unit_chk (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic       operation,
  input  logic [7:0] data_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] packed_byte,
  input  logic       run_last,
  input  logic       member_last,
  output int         fail_count,
  output int         bytes_pending
);

  localparam int MAXB = lzwe_pkg::MAX_CODE_BITS_DEF;
  localparam int NENT = lzwe_pkg::DICT_ENTRIES_DEF;

  typedef struct packed {
    logic [7:0] value;
    logic       run_end;
    logic       member_end;
  } packed_out_t;

  logic [13:0] kid [NENT];
  logic [13:0] sib [NENT];
  logic [7:0]  sym [NENT];
  int unsigned prefix_code, next_code, width, limit, bit_acc, bit_cnt;
  bit          in_member;
  packed_out_t expected_bytes[$];
  packed_out_t made[$];

  // push one code; emitted bytes go into made
  task automatic emit_code(input int unsigned code);
    longint unsigned acc;
    int unsigned     cnt;
    acc = longint'(bit_acc) | (longint'(code & ((1 << width) - 1)) << bit_cnt);
    cnt = bit_cnt + width;
    while (cnt >= 8) begin
      made.push_back('{acc[7:0], 1'b0, 1'b0});
      acc = acc >> 8;
      cnt -= 8;
    end
    bit_acc = acc[6:0];
    bit_cnt = cnt;
  endtask

  task automatic fresh_dict();
    for (int i = 0; i < 256; i++) kid[i] = '0;
    next_code = lzwe_pkg::CODE_FIRST;
    width = lzwe_pkg::START_WIDTH;
    limit = lzwe_pkg::START_LIMIT;
  endtask

  task automatic encode_request(input logic op, input logic [7:0] ch);
    int unsigned where, idx, link;
    int          hit;
    made.delete();
    if (op == lzwe_pkg::OP_DATA) begin
      if (!in_member) begin
        fresh_dict();
        emit_code(lzwe_pkg::CODE_CLEAR);
        prefix_code = ch;
        in_member = 1;
      end else begin
        where = prefix_code % NENT;
        idx = kid[where];
        hit = 2;
        while (idx != 0) begin
          if (sym[idx] == ch) begin
            hit = 0;
            where = idx;
            break;
          end
          where = idx;
          idx = sib[idx];
          hit = 1;
        end
        if (hit == 0) prefix_code = where;
        else begin
          link = next_code < NENT ? next_code : 0;
          emit_code(prefix_code);
          if (hit == 1) sib[where] = 14'(link);
          else kid[where] = 14'(link);
          if (next_code < NENT) begin
            kid[next_code] = '0;
            sib[next_code] = '0;
            sym[next_code] = ch;
          end
          if (next_code <= NENT) next_code++;
          prefix_code = ch;
          if (next_code > limit) begin
            if (width >= MAXB) begin
              emit_code(lzwe_pkg::CODE_CLEAR);
              fresh_dict();
            end else begin
              width++;
              limit = limit << 1;
            end
          end
        end
      end
    end else begin
      if (!in_member) begin
        fresh_dict();
        emit_code(lzwe_pkg::CODE_CLEAR);
      end else emit_code(prefix_code);
      emit_code(lzwe_pkg::CODE_EOF);
      if (bit_cnt != 0) made.push_back('{bit_acc[7:0], 1'b0, 1'b0});
      made[made.size()-1].member_end = 1'b1;
      bit_acc = 0;
      bit_cnt = 0;
      prefix_code = 0;
      in_member = 0;
    end
    if (made.size() > 0) made[made.size()-1].run_end = 1'b1;
    foreach (made[i]) expected_bytes.push_back(made[i]);
  endtask

  assign bytes_pending = expected_bytes.size();

  always @(posedge clk) begin
    packed_out_t want;
    if (rst) begin
      expected_bytes.delete();
      fail_count <= 0;
      prefix_code = 0;
      next_code = lzwe_pkg::CODE_FIRST;
      width = lzwe_pkg::START_WIDTH;
      limit = lzwe_pkg::START_LIMIT;
      bit_acc = 0;
      bit_cnt = 0;
      in_member = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected byte %h", packed_byte);
        end else begin
          want = expected_bytes.pop_front();
          if (want !== {packed_byte, run_last, member_last}) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp byte %h run %b mem %b, got %h %b %b",
                       want.value, want.run_end, want.member_end,
                       packed_byte, run_last, member_last);
          end
        end
      end
      if (push && !full) encode_request(operation, data_byte);
    end
  end
endmodule

FILE: test/lzw_variable_width_encoder_unit_tb.sv
// Testbench top for the LZW variable width encoder: stimulus and verdict.
// Depends on lzwe_pkg, the encoder RTL and lzw_variable_width_encoder_unit_chk.
`timescale 1ns / 1ps

module lzw_variable_width_encoder_unit_tb;

  logic       clk = 0, rst = 1, push = 0, operation = lzwe_pkg::OP_DATA, pop = 0;
  logic [7:0] data_byte = '0;
  logic       full, empty, run_last, member_last;
  logic [7:0] packed_byte;
  int         fail_count, bytes_pending;
  int         send_idle_pct = 0, recv_stall_pct = 0;
  longint     cycle_count = 0;

  lzw_variable_width_encoder_unit DUT (.*);

  lzw_variable_width_encoder_unit_chk checker_i (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) pop <= ($urandom_range(99) >= recv_stall_pct);

  // push stays high between back to back requests
  task automatic send(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(negedge clk);
    end
    push <= 1;
    operation <= op;
    data_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // member of len bytes from alpha symbols; a small alphabet lets matches grow
  task automatic send_member(input int len, input int alpha);
    for (int i = 0; i < len; i++) send(lzwe_pkg::OP_DATA, 8'($urandom_range(alpha - 1)));
    send(lzwe_pkg::OP_END, 8'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: empty member, extremes, repeats, end at odd lengths
    send(lzwe_pkg::OP_END, 8'hff);
    send(lzwe_pkg::OP_END, 8'h00);
    send(lzwe_pkg::OP_DATA, 8'h00);
    send(lzwe_pkg::OP_END, 8'h00);
    send(lzwe_pkg::OP_DATA, 8'hff); send(lzwe_pkg::OP_DATA, 8'hff);
    send(lzwe_pkg::OP_DATA, 8'hff); send(lzwe_pkg::OP_DATA, 8'hff);
    send(lzwe_pkg::OP_DATA, 8'h55); send(lzwe_pkg::OP_DATA, 8'haa);
    send(lzwe_pkg::OP_DATA, 8'h00); send(lzwe_pkg::OP_END, 8'h00);
    for (int i = 0; i < 8; i++) send(lzwe_pkg::OP_DATA, 8'(i));
    send(lzwe_pkg::OP_END, 8'hff);
    // pause until drained
    push <= 0;
    while (bytes_pending != 0) @(negedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 78 : 17) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 78 : 17) : 0;
      for (int m = 0; m < 6; m++)
        send_member($urandom_range(1, 24), ($urandom_range(3) == 0) ? 256 : 3);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // one longer member of arbitrary bytes
    send_member(75, 256);
    push <= 0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0 && bytes_pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
